### rtl/core/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler core.
// No dependencies; imported by every module under rtl/core.
package pps_pkg;

    localparam int TIME_W  = 17;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 12;
    localparam int PRIO_W  = 8;
    localparam int ID_W    = 4;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // input word
    typedef struct packed {
        logic               op;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } req_word_t;

    // result word
    typedef struct packed {
        logic              idle;
        logic [ID_W-1:0]   task_id;
        logic              finished;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              all_done;
        logic [TIME_W-1:0] idle_total;
    } res_word_t;

    // one task table entry
    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] left;
        logic [TIME_W-1:0]  start;
        logic               done;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_RUN,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic scan_rd;
        logic run;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_more;
    } ctrl_sts_t;

    function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
        return (v == TIME_MAX) ? v : v + 1'b1;
    endfunction

endpackage

### rtl/core/pps_ctrl.sv
// Sequencer for the scheduler: load, table scan, run update, result emit.
// Depends on pps_pkg.
module pps_ctrl
    import pps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      op,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd,
    output logic      busy
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (op == OP_TICK) ? S_SCAN : S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                // last read's compare lands in the cycle scan_more drops
                if (sts.scan_more)
                begin
                    cmd.scan_rd = 1'b1;
                end
                else
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.run    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/pps_datapath.sv
// Task table memory, scan compare, run update and result register.
// Depends on pps_pkg; driven by pps_ctrl commands.
module pps_datapath
    import pps_pkg::*;
#(
    parameter int MAX_TASKS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_cmd_t cmd,
    output ctrl_sts_t sts,
    input  req_word_t request,
    output res_word_t result,
    output logic      result_valid
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    entry_t mem [MAX_TASKS];

    // control state
    logic [CNT_W-1:0]  loaded_reg,   loaded_next;
    logic [CNT_W-1:0]  done_cnt_reg, done_cnt_next;
    logic [TIME_W-1:0] now_reg,      now_next;
    logic [TIME_W-1:0] idle_sum_reg, idle_sum_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              rd_vld_reg,   rd_vld_next;
    logic              best_vld_reg, best_vld_next;
    logic              res_vld_reg,  res_vld_next;

    // payload
    req_word_t         req_reg;
    entry_t            rd_data_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    entry_t            best_reg,     best_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic              fin_reg,      fin_next;
    logic [TIME_W-1:0] start_reg,    start_next;
    logic [TIME_W-1:0] comp_reg,     comp_next;
    logic [TIME_W-1:0] tat_reg,      tat_next;
    res_word_t         res_reg,      res_next;

    logic              room;
    logic              cand;
    logic              better;
    logic [TIME_W-1:0] now_inc;
    entry_t            upd;
    logic [TIME_W:0]   tat_diff;
    logic [TIME_W:0]   wait_diff;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;

    assign room          = (loaded_reg < CNT_W'(MAX_TASKS));
    assign sts.scan_more = (scan_idx_reg < loaded_reg);
    assign now_inc       = sat_inc(now_reg);

    // scan compare on the registered read
    always_comb
    begin
        cand   = rd_vld_reg && !rd_data_reg.done
                 && ({1'b0, rd_data_reg.arrival} <= now_reg);
        better = !best_vld_reg
                 || (rd_data_reg.prio > best_reg.prio)
                 || ((rd_data_reg.prio == best_reg.prio)
                     && (rd_data_reg.arrival < best_reg.arrival));
    end

    // picked task after one time unit
    always_comb
    begin
        upd = best_reg;
        if (best_reg.left == best_reg.burst)
        begin
            upd.start = now_reg;
        end
        if (best_reg.left != '0)
        begin
            upd.left = best_reg.left - 1'b1;
        end
        if (upd.left == '0)
        begin
            upd.done = 1'b1;
        end
        tat_diff  = {1'b0, now_inc} - {2'b0, best_reg.arrival};
        wait_diff = {1'b0, tat_reg} - {{(TIME_W - BURST_W + 1){1'b0}}, best_reg.burst};
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = loaded_reg[IDX_W-1:0];
        mem_wdata = '0;
        if (cmd.run)
        begin
            mem_we    = best_vld_reg;
            mem_waddr = best_idx_reg;
            mem_wdata = upd;
        end
        else if (cmd.load)
        begin
            mem_we            = room;
            mem_wdata.arrival = req_reg.arrival;
            mem_wdata.burst   = req_reg.burst;
            mem_wdata.prio    = req_reg.prio;
            mem_wdata.left    = req_reg.burst;
        end
    end

    always_comb
    begin
        loaded_next   = loaded_reg;
        done_cnt_next = done_cnt_reg;
        now_next      = now_reg;
        idle_sum_next = idle_sum_reg;
        scan_idx_next = scan_idx_reg;
        rd_vld_next   = cmd.scan_rd;
        best_vld_next = best_vld_reg;
        res_vld_next  = cmd.emit;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        fin_next      = fin_reg;
        start_next    = start_reg;
        comp_next     = comp_reg;
        tat_next      = tat_reg;
        res_next      = res_reg;

        if (cmd.capture)
        begin
            scan_idx_next = '0;
            best_vld_next = 1'b0;
        end
        if (cmd.load && room)
        begin
            loaded_next = loaded_reg + 1'b1;
        end
        if (cmd.scan_rd)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end
        if (cand && better)
        begin
            best_vld_next = 1'b1;
            best_next     = rd_data_reg;
            best_idx_next = rd_idx_reg;
        end
        if (cmd.run)
        begin
            now_next   = now_inc;
            fin_next   = 1'b0;
            start_next = upd.start;
            comp_next  = now_inc;
            tat_next   = tat_diff[TIME_W] ? '0 : tat_diff[TIME_W-1:0];
            if (best_vld_reg)
            begin
                fin_next = upd.done;
                if (upd.done)
                begin
                    done_cnt_next = done_cnt_reg + 1'b1;
                end
            end
            else
            begin
                idle_sum_next = sat_inc(idle_sum_reg);
            end
        end
        if (cmd.emit)
        begin
            res_next          = '0;
            res_next.idle     = !best_vld_reg;
            res_next.task_id  = best_vld_reg ? ID_W'(best_idx_reg) : '0;
            res_next.finished = fin_reg;
            if (fin_reg)
            begin
                res_next.start_time      = start_reg;
                res_next.completion_time = comp_reg;
                res_next.turnaround      = tat_reg;
                res_next.waiting         = wait_diff[TIME_W] ? '0 : wait_diff[TIME_W-1:0];
            end
            res_next.all_done   = (done_cnt_reg == loaded_reg);
            res_next.idle_total = idle_sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg   <= '0;
            done_cnt_reg <= '0;
            now_reg      <= '0;
            idle_sum_reg <= '0;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            loaded_reg   <= loaded_next;
            done_cnt_reg <= done_cnt_next;
            now_reg      <= now_next;
            idle_sum_reg <= idle_sum_next;
            scan_idx_reg <= scan_idx_next;
            rd_vld_reg   <= rd_vld_next;
            best_vld_reg <= best_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= request;
        end
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        fin_reg      <= fin_next;
        start_reg    <= start_next;
        comp_reg     <= comp_next;
        tat_reg      <= tat_next;
        res_reg      <= res_next;
    end

    // task table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.scan_rd)
        begin
            rd_data_reg <= mem[scan_idx_reg[IDX_W-1:0]];
            rd_idx_reg  <= scan_idx_reg[IDX_W-1:0];
        end
    end

    assign result       = res_reg;
    assign result_valid = res_vld_reg;

endmodule

### rtl/core/preemptive_priority_scheduler_core.sv
// Preemptive priority scheduler: a word is accepted only while busy is low,
// and busy stays high until that word is through: LOAD for a load word,
// SCAN, RUN and OUT for a tick word. A tick's result strobe comes in the
// first cycle busy is low again. The scan reads one table entry per cycle.
// No backpressure on results. rst_n (async, active low) clears counters and
// state; table entries hold no reset and are written on load.
// Depends on pps_pkg, pps_ctrl, pps_datapath.
module preemptive_priority_scheduler_core
    import pps_pkg::*;
#(
    parameter int MAX_TASKS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  req_word_t request,
    output res_word_t result,
    output logic      result_valid
);

    // controller <-> datapath handshake
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // The controller walks IDLE -> LOAD for a load word, and
    // IDLE -> SCAN -> RUN -> OUT for a tick word. SCAN reads one entry per
    // cycle; the winner (highest prio, then earliest arrival, then lowest
    // index) is kept in a register. RUN writes the picked entry back and
    // advances time; OUT forms the result word, strobed one cycle.
    pps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (request.op),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    pps_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .request      (request),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

### rtl/core/pps_checker.sv
// Port-level checks for the scheduler core, bound to the top level.
// Depends on pps_pkg and preemptive_priority_scheduler_core.
module pps_checker
    import pps_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input res_word_t result,
    input logic      result_valid
);

    // strobe is a single cycle
    a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    // an accepted word always makes the core busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // result only shows once the core is back idle
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while busy");

    // idle tick reports no task
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.idle) |-> (!result.finished && (result.task_id == '0)))
        else $error("idle tick reports a task");

    // timing fields are zero unless a task finished
    a_times_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.finished)
            |-> ((result.start_time == '0) && (result.turnaround == '0)
                 && (result.waiting == '0) && (result.completion_time == '0)))
        else $error("timing fields set without completion");

endmodule

bind preemptive_priority_scheduler_core pps_checker u_pps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid)
);
